// ===== design/hlfa_pkg.sv =====
// Package for the hole list allocator: sizes, codes, entry type, state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hlfa_pkg;

	localparam int HOLES     = 32;
	localparam int ADDR_BITS = 32;

	localparam int IW    = $clog2(HOLES);
	localparam int CW    = $clog2(HOLES + 1);
	localparam int BANKS = 3;
	localparam int AW    = $clog2(BANKS * HOLES);

	localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ADDR_BITS) - 64'd1);

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_RSVD  = 2'd3;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_NOFIT  = 3'd1;
	localparam logic [2:0] ST_FAILED = 3'd2;
	localparam logic [2:0] ST_FULL   = 3'd3;
	localparam logic [2:0] ST_BAD    = 3'd4;

	localparam logic [1:0] REG_TOTAL_SIZE = 2'd0;
	localparam logic [1:0] REG_FIT_MODE   = 2'd1;

	typedef struct packed {
		logic [31:0] base;
		logic [31:0] len;
	} hole_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CP_RD, S_CP_WR,
		S_A_DEC, S_FD_RD, S_FD_USE, S_A_PICK,
		S_SH_RD, S_SH_WR, S_A_FIN,
		S_F1_RD, S_F1_USE, S_F_CHK,
		S_F2_RD, S_F2_USE, S_F2_WR, S_F2_END,
		S_OUT
	} state_t;

	function automatic logic [AW-1:0] maddr(input logic [1:0] bank, input logic [IW-1:0] idx);
		return AW'(bank) * AW'(HOLES) + AW'(idx);
	endfunction

endpackage

`default_nettype wire

// ===== design/hole_list_fit_allocator.sv =====
// Hole list allocator top level: sequencer, bank pointers and hole table memory.
// Depends on hlfa_pkg.
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    tdata {seg_base, seg_size}, tuser opcode, tlast
//  m_*      out  m_tvalid/m_tready    tdata granted_base, tuser {group_ok, status}, tlast
//  cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item at a time; each table entry visited takes a read and a use state on the single
// registered read port. Allocate: copy to the saved bank at group start, scan, then shift
// if a hole empties. Free: merge pass, rebuild pass into spare bank. Clear: count to zero.
// No clearing pass after reset; a full result register holds the sequencer and input.
`timescale 1ns / 1ps
`default_nettype none

module hole_list_fit_allocator import hlfa_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // seg_size[31:0], seg_base[63:32]
	input  wire logic [1:0]  s_tuser,   // opcode
	input  wire logic        s_tlast,   // last_in_group
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // granted_base
	output logic [3:0]       m_tuser,   // status[2:0], group_ok[3]
	output logic             m_tlast,   // group_done
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	state_t state_q, state_d;

	hole_t mem_q [BANKS*HOLES];
	hole_t rdata_q;
	logic [AW-1:0] raddr, waddr;
	logic          we;
	hole_t         wdata;

	logic [31:0] total_q;
	logic        mode_q;

	logic [31:0]   size_q;
	logic          last_q;
	logic [CW-1:0] idx_q, n_q, touched_q, cnt_q, scnt_q;
	logic [1:0]    live_q, sav_q;
	logic          open_q, failed_q, found_q, placed_q;
	logic [IW-1:0] pk_idx_q;
	logic [31:0]   pk_b_q, pk_l_q;
	logic [31:0]   s_q;
	logic [32:0]   e_q;
	logic [31:0]   granted_q;
	logic [2:0]    status_q;
	logic          done_q, ok_q;

	logic [1:0]    spare;
	logic [CW-1:0] idx_m1;
	logic [31:0]   in_size, in_base, limit;
	logic [32:0]   in_end, cur_e;
	logic          ov, fits, out_load, bad_in;

	assign spare   = 2'd3 - live_q - sav_q;
	assign idx_m1  = idx_q - CW'(1);
	assign in_size = s_tdata[31:0] & ADDR_MASK;
	assign in_base = s_tdata[63:32] & ADDR_MASK;
	assign in_end  = {1'b0, in_base} + {1'b0, in_size};
	assign limit   = (total_q < ADDR_MASK) ? total_q : ADDR_MASK;
	assign cur_e   = {1'b0, rdata_q.base} + {1'b0, rdata_q.len};
	// entry overlaps or touches the hole being freed
	assign ov      = ({1'b0, rdata_q.base} <= e_q) && (cur_e >= {1'b0, s_q});
	assign fits    = rdata_q.len >= size_q;
	assign out_load = (state_q == S_OUT) && (!m_tvalid || m_tready);
	// free with bad range or zero size, or the unused opcode
	assign bad_in  = (s_tuser == OP_FREE && (in_size == '0 || in_end > {1'b0, limit})) ||
	                 s_tuser == OP_RSVD;

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		raddr   = maddr(live_q, idx_q[IW-1:0]);
		waddr   = maddr(live_q, idx_q[IW-1:0]);
		we      = 1'b0;
		wdata   = rdata_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					unique case (s_tuser)
						OP_ALLOC: state_d = open_q ? S_A_DEC : S_CP_RD;
						OP_FREE:  state_d = bad_in ? S_OUT : S_F1_RD;
						default:  state_d = S_OUT;
					endcase
				end
			end
			S_CP_RD: state_d = (idx_q == cnt_q) ? S_A_DEC : S_CP_WR;
			S_CP_WR: begin
				we      = 1'b1;
				waddr   = maddr(sav_q, idx_q[IW-1:0]);
				state_d = S_CP_RD;
			end
			S_A_DEC: state_d = (failed_q || size_q == '0) ? S_A_FIN : S_FD_RD;
			S_FD_RD: state_d = (idx_q == cnt_q) ? S_A_PICK : S_FD_USE;
			S_FD_USE: state_d = (fits && !mode_q) ? S_A_PICK : S_FD_RD;
			S_A_PICK: begin
				if (!found_q) begin
					state_d = S_A_FIN;
				end else if (pk_l_q == size_q) begin
					state_d = S_SH_RD;
				end else begin
					we         = 1'b1;
					waddr      = maddr(live_q, pk_idx_q);
					wdata.base = pk_b_q + size_q;
					wdata.len  = pk_l_q - size_q;
					state_d    = S_A_FIN;
				end
			end
			S_SH_RD: state_d = (idx_q == cnt_q) ? S_A_FIN : S_SH_WR;
			S_SH_WR: begin
				we      = 1'b1;
				waddr   = maddr(live_q, idx_m1[IW-1:0]);
				state_d = S_SH_RD;
			end
			S_A_FIN: state_d = S_OUT;
			S_F1_RD: state_d = (idx_q == cnt_q) ? S_F_CHK : S_F1_USE;
			S_F1_USE: state_d = S_F1_RD;
			S_F_CHK: state_d = (cnt_q - touched_q >= CW'(HOLES)) ? S_OUT : S_F2_RD;
			S_F2_RD: state_d = (idx_q == cnt_q) ? S_F2_END : S_F2_USE;
			S_F2_USE: begin
				waddr = maddr(spare, n_q[IW-1:0]);
				if (ov) begin
					state_d = S_F2_RD;
				end else if (!placed_q && rdata_q.base > s_q) begin
					we         = 1'b1;
					wdata.base = s_q;
					wdata.len  = 32'(e_q - {1'b0, s_q});
					state_d    = S_F2_WR;
				end else begin
					we      = 1'b1;
					state_d = S_F2_RD;
				end
			end
			S_F2_WR: begin
				we      = 1'b1;
				waddr   = maddr(spare, n_q[IW-1:0]);
				state_d = S_F2_RD;
			end
			S_F2_END: begin
				we         = !placed_q;
				waddr      = maddr(spare, n_q[IW-1:0]);
				wdata.base = s_q;
				wdata.len  = 32'(e_q - {1'b0, s_q});
				state_d    = S_OUT;
			end
			S_OUT: if (out_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= 32'hFFFF_FFFF;
			mode_q  <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TOTAL_SIZE: total_q <= cfg_data;
				REG_FIT_MODE:   mode_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			scnt_q   <= '0;
			live_q   <= 2'd0;
			sav_q    <= 2'd1;
			open_q   <= 1'b0;
			failed_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						size_q    <= in_size;
						last_q    <= s_tlast;
						idx_q     <= '0;
						touched_q <= '0;
						s_q       <= in_base;
						e_q       <= in_end;
						granted_q <= '0;
						status_q  <= bad_in ? ST_BAD : ST_OK;
						done_q    <= 1'b0;
						ok_q      <= 1'b0;
						if (s_tuser == OP_CLEAR) cnt_q <= '0;
					end
				end
				S_CP_RD: begin
					if (idx_q == cnt_q) begin
						scnt_q   <= cnt_q;
						open_q   <= 1'b1;
						failed_q <= 1'b0;
					end
				end
				S_CP_WR: idx_q <= idx_q + CW'(1);
				S_A_DEC: begin
					idx_q   <= '0;
					found_q <= 1'b0;
					if (failed_q) begin
						status_q <= ST_FAILED;
					end else if (size_q == '0) begin
						status_q <= ST_BAD;
						failed_q <= 1'b1;
					end
				end
				S_FD_USE: begin
					if (fits && (!found_q || (mode_q && rdata_q.len < pk_l_q))) begin
						found_q  <= 1'b1;
						pk_idx_q <= idx_q[IW-1:0];
						pk_b_q   <= rdata_q.base;
						pk_l_q   <= rdata_q.len;
					end
					idx_q <= idx_q + CW'(1);
				end
				S_A_PICK: begin
					if (!found_q) begin
						status_q <= ST_NOFIT;
						failed_q <= 1'b1;
					end else begin
						granted_q <= pk_b_q;
						idx_q     <= CW'(pk_idx_q) + CW'(1);
					end
				end
				S_SH_RD: if (idx_q == cnt_q) cnt_q <= cnt_q - CW'(1);
				S_SH_WR: idx_q <= idx_q + CW'(1);
				S_A_FIN: begin
					if (last_q) begin
						done_q   <= 1'b1;
						open_q   <= 1'b0;
						failed_q <= 1'b0;
						if (failed_q) begin
							// rollback: saved bank becomes live
							live_q <= sav_q;
							sav_q  <= live_q;
							cnt_q  <= scnt_q;
						end else begin
							ok_q <= 1'b1;
						end
					end
				end
				S_F1_USE: begin
					if (ov) begin
						if (rdata_q.base < s_q) s_q <= rdata_q.base;
						if (cur_e > e_q) e_q <= cur_e;
						touched_q <= touched_q + CW'(1);
					end
					idx_q <= idx_q + CW'(1);
				end
				S_F_CHK: begin
					idx_q    <= '0;
					n_q      <= '0;
					placed_q <= 1'b0;
					if (cnt_q - touched_q >= CW'(HOLES)) status_q <= ST_FULL;
				end
				S_F2_USE: begin
					if (ov) begin
						idx_q <= idx_q + CW'(1);
					end else if (!placed_q && rdata_q.base > s_q) begin
						n_q      <= n_q + CW'(1);
						placed_q <= 1'b1;
					end else begin
						n_q   <= n_q + CW'(1);
						idx_q <= idx_q + CW'(1);
					end
				end
				S_F2_WR: begin
					n_q   <= n_q + CW'(1);
					idx_q <= idx_q + CW'(1);
				end
				S_F2_END: begin
					cnt_q  <= n_q + CW'(!placed_q);
					live_q <= spare;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_load) begin
			m_tvalid <= 1'b1;
			m_tdata  <= granted_q;
			m_tuser  <= {ok_q, status_q};
			m_tlast  <= done_q;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for hole_list_fit_allocator: directed table, then random phases.
// Depends on hlfa_pkg and the allocator RTL; holds its own model of the hole table.
`timescale 1ns / 1ps

module tb_top import hlfa_pkg::*; ();

	typedef struct {
		logic [31:0] granted;
		logic [2:0]  status;
		logic        done;
		logic        ok;
	} alloc_res_t;

	typedef struct {
		logic [1:0]  op;
		logic [31:0] size;
		logic [31:0] base;
		logic        last;
		bit          typed;
		alloc_res_t  res;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [3:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	hole_list_fit_allocator u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// hole table model
	logic [31:0] hb [HOLES];
	logic [31:0] hl [HOLES];
	int          hcnt;
	logic [31:0] sv_b [HOLES];
	logic [31:0] sv_l [HOLES];
	int          sv_cnt;
	bit          grp_open;
	bit          grp_fail;
	logic [31:0] cfg_total;
	bit          cfg_best;

	alloc_res_t  pending_q[$];
	int          err_cnt;
	int          beats_in;
	int          beats_out;
	int          groups_ok;
	int          groups_bad;
	int          full_seen;
	bit          tx_gaps;
	bit          rx_gaps;
	int          hold_len;
	int          idle_cyc;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("ERROR t=%0t beat %0d: %s got %0h want %0h", $time, beats_out, what, got, want);
		err_cnt++;
	endtask

	function automatic logic [2:0] merge_free(input logic [31:0] base, input logic [31:0] size);
		logic [32:0] s, e, he;
		logic [31:0] nb [HOLES];
		logic [31:0] nl [HOLES];
		int          n, touched;
		bit          placed;
		if (size == 0) return ST_BAD;
		s = {1'b0, base};
		e = {1'b0, base} + {1'b0, size};
		if (e > {1'b0, cfg_total}) return ST_BAD;
		n = 0;
		touched = 0;
		placed = 0;
		for (int i = 0; i < hcnt; i++) begin
			he = {1'b0, hb[i]} + {1'b0, hl[i]};
			if ({1'b0, hb[i]} <= e && he >= s) begin
				if ({1'b0, hb[i]} < s) s = {1'b0, hb[i]};
				if (he > e) e = he;
				touched++;
			end
		end
		if (hcnt - touched + 1 > HOLES) return ST_FULL;
		// s and e now span the merged hole; rebuild the table in base order
		for (int i = 0; i < hcnt; i++) begin
			he = {1'b0, hb[i]} + {1'b0, hl[i]};
			if (!({1'b0, hb[i]} <= e && he >= s)) begin
				if (!placed && {1'b0, hb[i]} > s) begin
					nb[n] = s[31:0];
					nl[n] = 32'(e - s);
					n++;
					placed = 1;
				end
				nb[n] = hb[i];
				nl[n] = hl[i];
				n++;
			end
		end
		if (!placed) begin
			nb[n] = s[31:0];
			nl[n] = 32'(e - s);
			n++;
		end
		for (int i = 0; i < n; i++) begin
			hb[i] = nb[i];
			hl[i] = nl[i];
		end
		hcnt = n;
		return ST_OK;
	endfunction

	function automatic alloc_res_t table_step(input logic [1:0] op, input logic [31:0] size,
			input logic [31:0] base, input logic last);
		alloc_res_t r;
		int         pick;
		r = '{granted: '0, status: ST_OK, done: 1'b0, ok: 1'b0};
		if (op == OP_ALLOC) begin
			if (!grp_open) begin
				sv_b = hb;
				sv_l = hl;
				sv_cnt = hcnt;
				grp_open = 1;
				grp_fail = 0;
			end
			if (grp_fail) begin
				r.status = ST_FAILED;
			end else if (size == 0) begin
				r.status = ST_BAD;
				grp_fail = 1;
			end else begin
				pick = -1;
				for (int i = 0; i < hcnt; i++) begin
					if (hl[i] >= size && (pick < 0 || (cfg_best && hl[i] < hl[pick]))) pick = i;
				end
				if (pick < 0) begin
					r.status = ST_NOFIT;
					grp_fail = 1;
				end else begin
					r.granted = hb[pick];
					hb[pick] += size;
					hl[pick] -= size;
					if (hl[pick] == 0) begin
						for (int i = pick; i + 1 < hcnt; i++) begin
							hb[i] = hb[i + 1];
							hl[i] = hl[i + 1];
						end
						hcnt--;
					end
				end
			end
			if (last) begin
				r.done = 1'b1;
				if (grp_fail) begin
					hb = sv_b;
					hl = sv_l;
					hcnt = sv_cnt;
				end else begin
					r.ok = 1'b1;
				end
				grp_open = 0;
				grp_fail = 0;
			end
		end else if (op == OP_FREE) begin
			r.status = merge_free(base, size);
		end else if (op == OP_CLEAR) begin
			hcnt = 0;
		end else begin
			r.status = ST_BAD;
		end
		return r;
	endfunction

	// entered and left at a falling edge
	task automatic send_item(input logic [1:0] op, input logic [31:0] size,
			input logic [31:0] base, input logic last, input bit typed, input alloc_res_t want);
		alloc_res_t r;
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {base, size};
		s_tuser  <= op;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		r = table_step(op, size, base, last);
		pending_q.insert(pending_q.size(), typed ? want : r);
		beats_in++;
		@(negedge clk);
	endtask

	task automatic drain_and_pause();
		s_tvalid <= 1'b0;
		while (pending_q.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	// leaves cfg_valid high; the caller drops it after the last write
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_TOTAL_SIZE) cfg_total = val;
		else if (idx == REG_FIT_MODE) cfg_best = val[0];
		@(negedge clk);
	endtask

	task automatic random_items(input int n);
		alloc_res_t nil;
		int         k, g, span;
		int         pick;
		logic [31:0] sz;
		nil = '{granted: '0, status: ST_OK, done: 1'b0, ok: 1'b0};
		span = (cfg_total > 4096) ? 4096 : int'(cfg_total);
		k = 0;
		while (k < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 48) begin
				g = $urandom_range(1, 4);
				for (int j = 0; j < g; j++) begin
					sz = ($urandom_range(0, 19) == 0) ? $urandom : 32'($urandom_range(0, 24));
					send_item(OP_ALLOC, sz, $urandom, j == g - 1, 0, nil);
				end
				k += g;
			end else if (pick < 87) begin
				if ($urandom_range(0, 14) == 0)
					send_item(OP_FREE, $urandom, $urandom, $urandom_range(0, 1), 0, nil);
				else
					send_item(OP_FREE, $urandom_range(1, 64), $urandom_range(0, span),
						$urandom_range(0, 1), 0, nil);
				k++;
			end else if (pick < 92) begin
				send_item(OP_CLEAR, $urandom, $urandom, $urandom_range(0, 1), 0, nil);
				k++;
			end else if (pick < 96) begin
				send_item(OP_RSVD, $urandom, $urandom, $urandom_range(0, 1), 0, nil);
				k++;
			end else if (span >= 200) begin
				// fragment the table past its capacity
				send_item(OP_CLEAR, 0, 0, 0, 0, nil);
				for (int j = 0; j <= HOLES; j++)
					send_item(OP_FREE, $urandom_range(1, 2), 32'(j * 4), 0, 0, nil);
				k += HOLES + 2;
			end
		end
	endtask

	// receiver: random stall bursts plus an optional long hold-off
	initial begin
		int burst;
		burst = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_len > 0) begin
				m_tready <= 1'b0;
				hold_len--;
			end else if (burst > 0) begin
				m_tready <= 1'b0;
				burst--;
			end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
				burst = $urandom_range(1, 3) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		alloc_res_t w;
		if (arst_n && m_tvalid && m_tready) begin
			beats_out++;
			if (pending_q.size() == 0) begin
				report("unexpected beat", m_tdata, 32'd0);
			end else begin
				w = pending_q.pop_front();
				if (m_tdata !== w.granted) report("granted_base", m_tdata, w.granted);
				if (m_tuser[2:0] !== w.status)
					report("status", 32'(m_tuser[2:0]), 32'(w.status));
				if (m_tlast !== w.done) report("group_done", 32'(m_tlast), 32'(w.done));
				if (m_tuser[3] !== w.ok) report("group_ok", 32'(m_tuser[3]), 32'(w.ok));
				if (w.done && w.ok) groups_ok++;
				if (w.done && !w.ok) groups_bad++;
				if (w.status == ST_FULL) full_seen++;
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cyc <= 0;
		else
			idle_cyc <= idle_cyc + 1;
		if (idle_cyc > 20000) begin
			$display("watchdog: no handshake for %0d cycles", idle_cyc);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	localparam int DIR_ROWS = 16;

	initial begin
		dir_row_t    rows [DIR_ROWS];
		logic [31:0] totals [5];
		bit          modes [5];
		alloc_res_t  nil;
		nil = '{granted: '0, status: ST_OK, done: 1'b0, ok: 1'b0};
		rows = '{
			'{OP_ALLOC, 32'd5, 32'd0, 1'b1, 1, '{32'd0, ST_NOFIT, 1'b1, 1'b0}},
			'{OP_FREE, 32'd0, 32'd0, 1'b0, 1, '{32'd0, ST_BAD, 1'b0, 1'b0}},
			'{OP_RSVD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1, '{32'd0, ST_BAD, 1'b0, 1'b0}},
			'{OP_FREE, 32'h10, 32'hFFFF_FFF0, 1'b0, 1, '{32'd0, ST_BAD, 1'b0, 1'b0}},
			'{OP_FREE, 32'hF, 32'hFFFF_FFF0, 1'b0, 1, '{32'd0, ST_OK, 1'b0, 1'b0}},
			'{OP_FREE, 32'd100, 32'd0, 1'b0, 1, '{32'd0, ST_OK, 1'b0, 1'b0}},
			'{OP_FREE, 32'd50, 32'd100, 1'b0, 0, nil},          // touches, merges
			'{OP_FREE, 32'd20, 32'd140, 1'b1, 0, nil},          // overlaps
			'{OP_ALLOC, 32'd0, 32'hFFFF_FFFF, 1'b0, 1, '{32'd0, ST_BAD, 1'b0, 1'b0}},
			'{OP_ALLOC, 32'd10, 32'd0, 1'b1, 1, '{32'd0, ST_FAILED, 1'b1, 1'b0}},
			'{OP_ALLOC, 32'd10, 32'd0, 1'b0, 1, '{32'd0, ST_OK, 1'b0, 1'b0}},
			'{OP_FREE, 32'd7, 32'd500, 1'b0, 0, nil},           // free inside a group
			'{OP_ALLOC, 32'd150, 32'd0, 1'b1, 0, nil},          // empties a hole
			'{OP_ALLOC, 32'hFFFF_FFFF, 32'd0, 1'b1, 1, '{32'd0, ST_NOFIT, 1'b1, 1'b0}},
			'{OP_CLEAR, 32'd0, 32'd0, 1'b0, 1, '{32'd0, ST_OK, 1'b0, 1'b0}},
			'{OP_ALLOC, 32'd1, 32'd0, 1'b1, 1, '{32'd0, ST_NOFIT, 1'b1, 1'b0}}
		};
		totals = '{32'hFFFF_FFFF, 32'd4096, 32'd1, 32'h8000_0000, 32'hFFFF_FFFF};
		modes  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0};

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		s_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hcnt = 0;
		sv_cnt = 0;
		grp_open = 0;
		grp_fail = 0;
		cfg_total = 32'hFFFF_FFFF;
		cfg_best = 0;
		err_cnt = 0;
		beats_in = 0;
		beats_out = 0;
		groups_ok = 0;
		groups_bad = 0;
		full_seen = 0;
		tx_gaps = 1;
		rx_gaps = 1;
		hold_len = 0;
		idle_cyc = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i])
			send_item(rows[i].op, rows[i].size, rows[i].base, rows[i].last, rows[i].typed,
				rows[i].res);

		for (int ph = 0; ph < 5; ph++) begin
			drain_and_pause();
			if (ph == 4) begin
				tx_gaps = 0;
				rx_gaps = 0;
			end
			write_reg(REG_TOTAL_SIZE, totals[ph]);
			write_reg(REG_FIT_MODE, 32'(modes[ph]));
			cfg_valid <= 1'b0;
			if (ph == 1) hold_len = 300;    // sink stalls while source keeps pushing
			random_items(45);
			if (ph == 2) drain_and_pause();
			random_items(45);
		end

		s_tvalid <= 1'b0;
		while (pending_q.size() != 0) @(negedge clk);
		repeat (300) @(posedge clk);
		$display("covered %0d items, %0d results; groups committed %0d, rolled back %0d",
			beats_in, beats_out, groups_ok, groups_bad);
		$display("table-full rejects %0d; first and best fit, total sizes from 1 to max",
			full_seen);
		if (err_cnt == 0 && pending_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== hole_list_fit_allocator.f =====
design/hlfa_pkg.sv
design/hole_list_fit_allocator.sv
tb/tb_top.sv
